// ===== hdl/wmc_pkg.sv =====
`timescale 1ns / 1ps

package wmc_pkg;

    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 5;
    localparam int WIDTH_W = 6;
    localparam int SLOT_OUT_W = 5;
    localparam int SHIFT_W = 4;

    localparam logic [SIZE_W-1:0]  SIZE_HALF    = 5'd8;
    localparam logic [SIZE_W-1:0]  SIZE_QUARTER = 5'd16;
    localparam logic [WIDTH_W-1:0] WIDTH_MAX    = 6'd63;
    localparam logic [SHIFT_W-1:0] LINE_SHIFT_RESET = 4'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MERGE,
        ST_EMIT
    } wmc_state_t;

    typedef struct packed {
        logic load;
        logic merge;
        logic emit;
    } wmc_cmd_t;

    typedef struct packed {
        logic close;
        logic emit_last;
        logic out_free;
    } wmc_sts_t;

endpackage

// ===== hdl/wmc_ctrl.sv =====
`timescale 1ns / 1ps

module wmc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output wmc_pkg::wmc_cmd_t cmd,
    input  wmc_pkg::wmc_sts_t sts
);
    import wmc_pkg::*;

    wmc_state_t state_reg;
    wmc_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE: begin
                cmd.merge  = 1'b1;
                state_next = sts.close ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                cmd.emit = sts.out_free;
                if (sts.out_free && sts.emit_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/wmc_datapath.sv =====
`timescale 1ns / 1ps

module wmc_datapath #(
    parameter int LANE_COUNT = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic [wmc_pkg::SHIFT_W-1:0]      cfg_data,
    input  logic                             in_active,
    input  logic [wmc_pkg::ADDR_W-1:0]       in_address,
    input  logic [wmc_pkg::ADDR_W-1:0]       in_end_addr,
    input  logic [wmc_pkg::SIZE_W-1:0]       in_size_bytes,
    input  logic [wmc_pkg::WIDTH_W-1:0]      in_start_width,
    input  logic                             in_last,
    input  wmc_pkg::wmc_cmd_t                cmd,
    output wmc_pkg::wmc_sts_t                sts,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic [wmc_pkg::SLOT_OUT_W-1:0]   out_thread_slot,
    output logic                             out_slot_active,
    output logic [wmc_pkg::WIDTH_W-1:0]      out_width,
    output logic [wmc_pkg::ADDR_W-1:0]       out_merged_end,
    output logic                             out_final_res
);
    import wmc_pkg::*;

    localparam int SLOT_W      = $clog2(LANE_COUNT);
    localparam int HALF_LEN    = LANE_COUNT / 2;
    localparam int QUARTER_LEN = LANE_COUNT / 4;

    logic [SHIFT_W-1:0] line_shift_reg;

    logic               act_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  end_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [WIDTH_W-1:0] wid_reg;
    logic               last_reg;

    logic [ADDR_W-1:0]  addr_mem  [LANE_COUNT];
    logic [ADDR_W-1:0]  end_mem   [LANE_COUNT];
    logic [WIDTH_W-1:0] width_mem [LANE_COUNT];
    logic [LANE_COUNT-1:0] valid_reg;

    logic [SLOT_W-1:0] fill_reg;
    logic [SLOT_W-1:0] base_half_reg;
    logic [SLOT_W-1:0] base_quarter_reg;
    logic [SLOT_W-1:0] emit_idx_reg;

    logic                  m_tvalid_reg;
    logic [SLOT_OUT_W-1:0] slot_out_reg;
    logic                  active_out_reg;
    logic [WIDTH_W-1:0]    width_out_reg;
    logic [ADDR_W-1:0]     end_out_reg;
    logic                  final_out_reg;

    logic [ADDR_W-1:0]     line_mask;
    logic [SLOT_W-1:0]     group_base;
    logic [LANE_COUNT-1:0] hit_vec;
    logic [LANE_COUNT-1:0] eq_vec;
    logic                  hit_any;
    logic [SLOT_W-1:0]     lead_idx;
    logic                  addr_diff;
    logic [SLOT_W-1:0]     rd_idx;
    logic [ADDR_W-1:0]     end_rd;
    logic [WIDTH_W-1:0]    width_rd;
    logic [ADDR_W-1:0]     end_max;
    logic [WIDTH_W-1:0]    width_inc;
    logic [SLOT_W-1:0]     next_slot;

    assign line_mask = {ADDR_W{1'b1}} << line_shift_reg;

    always_comb begin
        case (size_reg)
            SIZE_HALF:    group_base = base_half_reg;
            SIZE_QUARTER: group_base = base_quarter_reg;
            default:      group_base = '0;
        endcase
    end

    always_comb begin
        for (int j = 0; j < LANE_COUNT; j++) begin
            eq_vec[j]  = (addr_mem[j] == addr_reg);
            hit_vec[j] = act_reg && valid_reg[j]
                         && (SLOT_W'(j) >= group_base) && (SLOT_W'(j) < fill_reg)
                         && (((addr_mem[j] ^ addr_reg) & line_mask) == '0);
        end
    end

    always_comb begin
        lead_idx = '0;
        for (int j = LANE_COUNT - 1; j >= 0; j--) begin
            if (hit_vec[j]) begin
                lead_idx = SLOT_W'(j);
            end
        end
    end

    assign hit_any   = |hit_vec;
    assign addr_diff = !eq_vec[lead_idx];
    assign rd_idx    = cmd.merge ? lead_idx : emit_idx_reg;
    assign end_rd    = end_mem[rd_idx];
    assign width_rd  = width_mem[rd_idx];
    assign end_max   = (end_reg > end_rd) ? end_reg : end_rd;
    assign width_inc = (width_rd == WIDTH_MAX) ? width_rd : width_rd + 6'd1;
    assign next_slot = fill_reg + SLOT_W'(1);

    assign sts.close     = last_reg || (fill_reg == SLOT_W'(LANE_COUNT - 1));
    assign sts.emit_last = (emit_idx_reg == fill_reg);
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_shift_reg <= LINE_SHIFT_RESET;
        end else if (cfg_valid) begin
            line_shift_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg  <= in_active;
            addr_reg <= in_address;
            end_reg  <= in_end_addr;
            size_reg <= in_size_bytes;
            wid_reg  <= in_start_width;
            last_reg <= in_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.merge) begin
            addr_mem[fill_reg]  <= addr_reg;
            end_mem[fill_reg]   <= end_reg;
            width_mem[fill_reg] <= hit_any ? '0 : wid_reg;
            if (hit_any && addr_diff) begin
                end_mem[lead_idx]   <= end_max;
                width_mem[lead_idx] <= width_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg        <= '0;
            fill_reg         <= '0;
            base_half_reg    <= '0;
            base_quarter_reg <= '0;
            emit_idx_reg     <= '0;
        end else if (cmd.merge) begin
            valid_reg[fill_reg] <= act_reg;
            if (!sts.close) begin
                fill_reg <= next_slot;
                if (next_slot - base_half_reg == SLOT_W'(HALF_LEN)) begin
                    base_half_reg <= next_slot;
                end
                if (next_slot - base_quarter_reg == SLOT_W'(QUARTER_LEN)) begin
                    base_quarter_reg <= next_slot;
                end
            end
        end else if (cmd.emit) begin
            if (sts.emit_last) begin
                valid_reg        <= '0;
                fill_reg         <= '0;
                base_half_reg    <= '0;
                base_quarter_reg <= '0;
                emit_idx_reg     <= '0;
            end else begin
                emit_idx_reg <= emit_idx_reg + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            slot_out_reg   <= SLOT_OUT_W'(emit_idx_reg);
            active_out_reg <= valid_reg[emit_idx_reg];
            width_out_reg  <= valid_reg[emit_idx_reg] ? width_rd : '0;
            end_out_reg    <= valid_reg[emit_idx_reg] ? end_rd : '0;
            final_out_reg  <= sts.emit_last;
        end
    end

    assign m_tvalid        = m_tvalid_reg;
    assign out_thread_slot = slot_out_reg;
    assign out_slot_active = active_out_reg;
    assign out_width       = width_out_reg;
    assign out_merged_end  = end_out_reg;
    assign out_final_res   = final_out_reg;

endmodule

// ===== hdl/warp_memory_coalescer.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Transfer carries
// s_        in         one thread access: tdata address/end/size/width, tuser active, tlast
// m_        out        one slot result: tdata slot/width/end, tuser active, tlast final
// cfg_      in         line_shift (log2 of the cache line size)
//
// Each access is captured, then goes through a compare-and-merge step in which the valid
// slots of its size group, from the group base up to the fill pointer, are matched against the new line in parallel.
// After the warp closes (tlast or a full warp), one slot result leaves per cycle;
// the m_ side stalls that sweep when m_tready is low.
// aresetn is synchronous; it clears slot valid bits, counters and line_shift (to 7).
// s_tready is low during merge and emit cycles.

module warp_memory_coalescer #(
    parameter int LANE_COUNT = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // address[31:0], end_addr[63:32], size_bytes[68:64],
                                   // start_width[74:69], zero[79:75]
    input  logic [0:0]  s_tuser,   // active[0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // thread_slot[4:0], width[10:5], merged_end[42:11],
                                   // zero[47:43]
    output logic [0:0]  m_tuser,   // slot_active[0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);
    import wmc_pkg::*;

    wmc_cmd_t cmd;
    wmc_sts_t sts;

    logic [SLOT_OUT_W-1:0] out_thread_slot;
    logic [WIDTH_W-1:0]    out_width;
    logic [ADDR_W-1:0]     out_merged_end;
    logic                  out_slot_active;

    assign cfg_ready = 1'b1;

    wmc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    wmc_datapath #(
        .LANE_COUNT (LANE_COUNT)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .in_active       (s_tuser[0]),
        .in_address      (s_tdata[31:0]),
        .in_end_addr     (s_tdata[63:32]),
        .in_size_bytes   (s_tdata[68:64]),
        .in_start_width  (s_tdata[74:69]),
        .in_last         (s_tlast),
        .cmd             (cmd),
        .sts             (sts),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .out_thread_slot (out_thread_slot),
        .out_slot_active (out_slot_active),
        .out_width       (out_width),
        .out_merged_end  (out_merged_end),
        .out_final_res   (m_tlast)
    );

    assign m_tdata = {5'd0, out_merged_end, out_width, out_thread_slot};
    assign m_tuser = out_slot_active;

`ifndef NO_ASSERTIONS
    a_merge_after_accept: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready
    ) else $error("input accepted during merge cycle");

    a_hold_result: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    ) else $error("result changed while stalled");

    a_no_accept_while_emit: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> !s_tready
    ) else $error("input accepted while warp results pending");
`endif

endmodule
